// ===== src/ps2_keyboard_command_responder_core_defines.svh =====
// ---------------------------------------------------------------------------
// PS/2 keyboard command responder assertion macros
// Concurrent assertion wrappers that drop out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PS2_KEYBOARD_COMMAND_RESPONDER_CORE_DEFINES_SVH
`define PS2_KEYBOARD_COMMAND_RESPONDER_CORE_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define KBDCR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kbdcr assertion failed");
// Antecedent in one cycle implies consequent in the next cycle.
`define KBDCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kbdcr assertion failed");
`else
`define KBDCR_ASSERT(label, prop)
`define KBDCR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/kbdcr_pkg.sv =====
// ---------------------------------------------------------------------------
// PS/2 keyboard command responder package
// Command codes, response codes, receive phases and typematic tables.
// ---------------------------------------------------------------------------
package kbdcr_pkg;

  // Host command bytes.
  localparam logic [7:0] CMD_SET_LEDS     = 8'hED;
  localparam logic [7:0] CMD_ECHO         = 8'hEE;
  localparam logic [7:0] CMD_SCAN_SET     = 8'hF0;
  localparam logic [7:0] CMD_READ_ID      = 8'hF2;
  localparam logic [7:0] CMD_TYPEMATIC    = 8'hF3;
  localparam logic [7:0] CMD_ENABLE       = 8'hF4;
  localparam logic [7:0] CMD_DISABLE      = 8'hF5;
  localparam logic [7:0] CMD_DEFAULTS     = 8'hF6;
  localparam logic [7:0] CMD_ALL_TM       = 8'hF7;
  localparam logic [7:0] CMD_ALL_MB       = 8'hF8;
  localparam logic [7:0] CMD_ALL_MK       = 8'hF9;
  localparam logic [7:0] CMD_ALL_TMB      = 8'hFA;
  localparam logic [7:0] CMD_KEY_TM       = 8'hFB;
  localparam logic [7:0] CMD_KEY_MB       = 8'hFC;
  localparam logic [7:0] CMD_KEY_MK       = 8'hFD;
  localparam logic [7:0] CMD_RESEND       = 8'hFE;
  localparam logic [7:0] CMD_RESET        = 8'hFF;

  // Scan set argument that asks for the current set.
  localparam logic [7:0] SCAN_SET_QUERY   = 8'h00;

  // Typematic defaults and reset values.
  localparam logic [4:0] RATE_IDX_RESET   = 5'h08;
  localparam logic [4:0] RATE_IDX_DEFAULT = 5'h0B;
  localparam logic [1:0] DELAY_IDX_DEFLT  = 2'h1;

  // Response codes sent back to the host.
  typedef enum logic [2:0] {
    RSP_ACK   = 3'd0,
    RSP_ECHO  = 3'd1,
    RSP_ID    = 3'd2,
    RSP_BAT   = 3'd3,
    RSP_SET2  = 3'd4,
    RSP_ERROR = 3'd5
  } kbdcr_rsp_t;

  // Receive phase: what the next non-command byte means.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEDS    = 3'd1,
    PH_SCANSET = 3'd2,
    PH_REPEAT  = 3'd3,
    PH_KEYLIST = 3'd4
  } kbdcr_phase_t;

  // Everything one host byte produces, held until all its beats are sent.
  typedef struct packed {
    kbdcr_rsp_t  code0;
    kbdcr_rsp_t  code1;
    logic        two;
    logic        led_valid;
    logic [7:0]  led_byte;
    logic [1:0]  delay_idx;
    logic [4:0]  rate_idx;
    logic        unlock;
  } kbdcr_rec_t;

  // Typematic delay in timer ticks.
  localparam logic [13:0] DELAY_TAB [4] = '{
    14'd3750, 14'd7500, 14'd11250, 14'd15000
  };

  // Magnitudes of the repeat periods in timer ticks.
  localparam logic [12:0] RATE_MAG [32] = '{
    13'd500,  13'd562,  13'd625,  13'd688,  13'd725,  13'd811,  13'd877,  13'd938,
    13'd1000, 13'd1128, 13'd1250, 13'd1376, 13'd1500, 13'd1630, 13'd1744, 13'd1875,
    13'd2000, 13'd2239, 13'd2500, 13'd2727, 13'd3000, 13'd3261, 13'd3488, 13'd3750,
    13'd4054, 13'd4545, 13'd5000, 13'd5556, 13'd6000, 13'd6522, 13'd7143, 13'd7500
  };

  function automatic logic [13:0] delay_ticks(input logic [1:0] idx);
    return DELAY_TAB[idx];
  endfunction

  // Repeat period as a negative tick count.
  function automatic logic signed [13:0] rate_ticks(input logic [4:0] idx);
    logic signed [13:0] mag;
    mag = $signed({1'b0, RATE_MAG[idx]});
    return -mag;
  endfunction

endpackage

// ===== src/ps2_keyboard_command_responder_core.sv =====
// ---------------------------------------------------------------------------
// PS/2 keyboard command responder
// Device-side decoder for host bytes on the keyboard port.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_host_byte) carries one host
//   byte per beat. The result channel (out_valid, out_stall, out_*) carries
//   one response code per beat; a byte produces one or two beats, and
//   out_last_response marks the final one. LED and typematic fields and
//   out_send_unlock are the same on both beats of one byte.
//   A byte is decoded in the cycle it is accepted and its results sit in a
//   two-entry result queue; its first beat is offered once the entry is
//   registered and at the head. A byte may be accepted in every cycle while
//   the queue has room, so the sustained rate is one byte per cycle for
//   single-beat responses while the receiver does not stall; two-beat ones
//   are bounded by the single output port. in_stall rises only when both
//   queue entries are occupied. When the receiver stalls, the head beat holds
//   and the queue fills. Reset empties the queue, returns the receive phase to
//   idle and loads rate index 8 and delay index 1.
// ---------------------------------------------------------------------------
`include "ps2_keyboard_command_responder_core_defines.svh"

module ps2_keyboard_command_responder_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_host_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_response_code,
  output logic                     out_last_response,
  output logic                     out_led_valid,
  output logic [7:0]               out_led_byte,
  output logic [13:0]              out_repeat_delay_ticks,
  output logic signed [13:0]       out_repeat_rate_ticks,
  output logic                     out_send_unlock
);
  import kbdcr_pkg::*;

  // Protocol state.
  kbdcr_phase_t phase_r, phase_nxt;
  logic [4:0]   rate_idx_r, rate_idx_nxt;
  logic [1:0]   delay_idx_r, delay_idx_nxt;

  // Result queue.
  kbdcr_rec_t   rec_r [2];
  kbdcr_rec_t   rec_nxt;
  logic         wr_ptr_r, rd_ptr_r, sub_r;
  logic [1:0]   count_r;
  logic         in_fire, out_fire, pop;
  kbdcr_rec_t   head;

  assign in_stall  = (count_r == 2'd2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (count_r != 2'd0);
  assign out_fire  = out_valid && !out_stall;
  assign head      = rec_r[rd_ptr_r];
  assign pop       = out_fire && (sub_r || !head.two);

  // Decode the host byte against the current phase.
  always_comb begin
    phase_nxt     = phase_r;
    rate_idx_nxt  = rate_idx_r;
    delay_idx_nxt = delay_idx_r;
    rec_nxt.code0     = RSP_ACK;
    rec_nxt.code1     = RSP_ACK;
    rec_nxt.two       = 1'b0;
    rec_nxt.led_valid = 1'b0;
    rec_nxt.led_byte  = 8'h00;
    unique case (in_host_byte) inside
      CMD_SET_LEDS: phase_nxt = PH_LEDS;
      CMD_ECHO: begin
        rec_nxt.code0 = RSP_ECHO;
        phase_nxt     = PH_IDLE;
      end
      CMD_SCAN_SET: phase_nxt = PH_SCANSET;
      CMD_READ_ID: begin
        rec_nxt.code1 = RSP_ID;
        rec_nxt.two   = 1'b1;
        phase_nxt     = PH_IDLE;
      end
      CMD_TYPEMATIC: phase_nxt = PH_REPEAT;
      CMD_ENABLE, CMD_ALL_TM, CMD_ALL_MB, CMD_ALL_MK, CMD_ALL_TMB: phase_nxt = PH_IDLE;
      CMD_DISABLE, CMD_DEFAULTS: begin
        rate_idx_nxt  = RATE_IDX_DEFAULT;
        delay_idx_nxt = DELAY_IDX_DEFLT;
        phase_nxt     = PH_IDLE;
      end
      CMD_KEY_TM, CMD_KEY_MB, CMD_KEY_MK: phase_nxt = PH_KEYLIST;
      CMD_RESEND: phase_nxt = phase_r;
      CMD_RESET: begin
        rate_idx_nxt  = RATE_IDX_DEFAULT;
        delay_idx_nxt = DELAY_IDX_DEFLT;
        rec_nxt.code1 = RSP_BAT;
        rec_nxt.two   = 1'b1;
        phase_nxt     = PH_IDLE;
      end
      default: begin
        // Argument byte for the pending phase.
        unique case (phase_r)
          PH_LEDS: begin
            rec_nxt.led_valid = 1'b1;
            rec_nxt.led_byte  = in_host_byte;
            phase_nxt         = PH_IDLE;
          end
          PH_REPEAT: begin
            rate_idx_nxt  = in_host_byte[4:0];
            delay_idx_nxt = in_host_byte[6:5];
            phase_nxt     = PH_IDLE;
          end
          PH_SCANSET: begin
            if (in_host_byte == SCAN_SET_QUERY) begin
              rec_nxt.code1 = RSP_SET2;
              rec_nxt.two   = 1'b1;
            end
            phase_nxt = PH_IDLE;
          end
          PH_KEYLIST: phase_nxt = PH_KEYLIST;
          default: begin
            rec_nxt.code0 = RSP_ERROR;
            phase_nxt     = PH_IDLE;
          end
        endcase
      end
    endcase
    rec_nxt.delay_idx = delay_idx_nxt;
    rec_nxt.rate_idx  = rate_idx_nxt;
    rec_nxt.unlock    = (phase_nxt == PH_IDLE);
  end

  // Protocol state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      rate_idx_r  <= RATE_IDX_RESET;
      delay_idx_r <= DELAY_IDX_DEFLT;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      rate_idx_r  <= rate_idx_nxt;
      delay_idx_r <= delay_idx_nxt;
    end
  end

  // Queue payload storage.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec_r[wr_ptr_r] <= rec_nxt;
    end
  end

  // Queue pointers, fill count and beat select within the head entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      sub_r    <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        sub_r    <= 1'b0;
      end else if (out_fire) begin
        sub_r    <= 1'b1;
      end
      case ({in_fire, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Result beat drive.
  assign out_response_code      = sub_r ? head.code1 : head.code0;
  assign out_last_response      = sub_r || !head.two;
  assign out_led_valid          = head.led_valid;
  assign out_led_byte           = head.led_byte;
  assign out_repeat_delay_ticks = delay_ticks(head.delay_idx);
  assign out_repeat_rate_ticks  = rate_ticks(head.rate_idx);
  assign out_send_unlock        = head.unlock;

  // Checks.
  `KBDCR_ASSERT(a_count_bound, count_r != 2'd3)
  `KBDCR_ASSERT(a_sub_two, !sub_r || (out_valid && head.two))
  `KBDCR_ASSERT_NEXT(a_fill, in_fire && !pop, count_r == $past(count_r) + 2'd1)
  `KBDCR_ASSERT_NEXT(a_echo_idle, in_fire && in_host_byte == CMD_ECHO, phase_r == PH_IDLE)

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// PS/2 keyboard command responder testbench
// Feeds host bytes through the input channel and predicts the response beats
// of every accepted byte. Each beat on the result channel is checked field by
// field against the oldest prediction. A short directed table comes first and
// is followed by random command and argument sequences. The input channel
// idles and the receiver stalls at random.
// ---------------------------------------------------------------------------
module testbench;

  import kbdcr_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 2000;

  // Typematic delay in timer ticks, indexed by the delay field.
  localparam logic [13:0] DELAY_TICK_TAB [4] = '{
    14'd3750, 14'd7500, 14'd11250, 14'd15000
  };

  // Repeat period magnitudes in timer ticks, indexed by the rate field.
  localparam logic [13:0] RATE_MAG_TAB [32] = '{
    14'd500,  14'd562,  14'd625,  14'd688,  14'd725,  14'd811,  14'd877,  14'd938,
    14'd1000, 14'd1128, 14'd1250, 14'd1376, 14'd1500, 14'd1630, 14'd1744, 14'd1875,
    14'd2000, 14'd2239, 14'd2500, 14'd2727, 14'd3000, 14'd3261, 14'd3488, 14'd3750,
    14'd4054, 14'd4545, 14'd5000, 14'd5556, 14'd6000, 14'd6522, 14'd7143, 14'd7500
  };

  // One response beat as it appears on the result channel.
  typedef struct packed {
    kbdcr_rsp_t         code;
    logic               last_rsp;
    logic               led_valid;
    logic [7:0]         led_byte;
    logic [13:0]        delay_tk;
    logic signed [13:0] rate_tk;
    logic               unlock;
  } rsp_beat_t;

  // One host byte to send, with a hand-written expectation where it is typed.
  typedef struct {
    logic [7:0]         hb;
    bit                 typed;
    kbdcr_rsp_t         code;
    logic [13:0]        delay_tk;
    logic signed [13:0] rate_tk;
    logic               unlock;
  } host_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_host_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_response_code;
  logic               out_last_response;
  logic               out_led_valid;
  logic [7:0]         out_led_byte;
  logic [13:0]        out_repeat_delay_ticks;
  logic signed [13:0] out_repeat_rate_ticks;
  logic               out_send_unlock;

  host_row_t    host_rows[$];
  rsp_beat_t    expected_beats[$];
  int           rows_taken = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  kbdcr_phase_t kb_phase;
  logic [4:0]   kb_rate_idx;
  logic [1:0]   kb_delay_idx;

  ps2_keyboard_command_responder_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_host_byte           (in_host_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_response_code      (out_response_code),
    .out_last_response      (out_last_response),
    .out_led_valid          (out_led_valid),
    .out_led_byte           (out_led_byte),
    .out_repeat_delay_ticks (out_repeat_delay_ticks),
    .out_repeat_rate_ticks  (out_repeat_rate_ticks),
    .out_send_unlock        (out_send_unlock)
  );

  always #5 clk = ~clk;

  // Queue a host byte whose responses come from the predictor alone.
  task automatic add_row(input logic [7:0] hb);
    host_row_t row;
    row.hb       = hb;
    row.typed    = 1'b0;
    row.code     = RSP_ACK;
    row.delay_tk = '0;
    row.rate_tk  = '0;
    row.unlock   = 1'b0;
    host_rows.push_back(row);
  endtask

  // Queue a host byte with its first response code, tick fields and unlock flag typed in.
  task automatic add_typed_row(input logic [7:0] hb, input kbdcr_rsp_t code,
                               input logic [13:0] delay_tk,
                               input logic signed [13:0] rate_tk,
                               input logic unlock);
    host_row_t row;
    row.hb       = hb;
    row.typed    = 1'b1;
    row.code     = code;
    row.delay_tk = delay_tk;
    row.rate_tk  = rate_tk;
    row.unlock   = unlock;
    host_rows.push_back(row);
  endtask

  // Draw a byte that the keyboard takes as an argument, never as a command.
  function automatic logic [7:0] argument_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CMD_SET_LEDS || b == CMD_ECHO || b == CMD_SCAN_SET ||
               b >= CMD_READ_ID);
    return b;
  endfunction

  // Decode one host byte, update the keyboard state and queue its beats.
  task automatic respond_to_host_byte(input logic [7:0] hb);
    kbdcr_rsp_t codes[$];
    rsp_beat_t  beat;
    logic       led_v;
    logic [7:0] led_b;
    led_v = 1'b0;
    led_b = 8'h00;
    case (hb)
      CMD_SET_LEDS: begin
        codes.push_back(RSP_ACK);
        kb_phase = PH_LEDS;
      end
      CMD_ECHO: begin
        codes.push_back(RSP_ECHO);
        kb_phase = PH_IDLE;
      end
      CMD_SCAN_SET: begin
        codes.push_back(RSP_ACK);
        kb_phase = PH_SCANSET;
      end
      CMD_READ_ID: begin
        codes.push_back(RSP_ACK);
        codes.push_back(RSP_ID);
        kb_phase = PH_IDLE;
      end
      CMD_TYPEMATIC: begin
        codes.push_back(RSP_ACK);
        kb_phase = PH_REPEAT;
      end
      CMD_ENABLE, CMD_ALL_TM, CMD_ALL_MB, CMD_ALL_MK, CMD_ALL_TMB: begin
        codes.push_back(RSP_ACK);
        kb_phase = PH_IDLE;
      end
      CMD_DISABLE, CMD_DEFAULTS: begin
        codes.push_back(RSP_ACK);
        kb_delay_idx = DELAY_IDX_DEFLT;
        kb_rate_idx  = RATE_IDX_DEFAULT;
        kb_phase     = PH_IDLE;
      end
      CMD_KEY_TM, CMD_KEY_MB, CMD_KEY_MK: begin
        codes.push_back(RSP_ACK);
        kb_phase = PH_KEYLIST;
      end
      CMD_RESEND: begin
        codes.push_back(RSP_ACK);
      end
      CMD_RESET: begin
        codes.push_back(RSP_ACK);
        codes.push_back(RSP_BAT);
        kb_delay_idx = DELAY_IDX_DEFLT;
        kb_rate_idx  = RATE_IDX_DEFAULT;
        kb_phase     = PH_IDLE;
      end
      default: begin
        // Not a command, so the byte is the argument of the pending phase.
        case (kb_phase)
          PH_LEDS: begin
            codes.push_back(RSP_ACK);
            led_v    = 1'b1;
            led_b    = hb;
            kb_phase = PH_IDLE;
          end
          PH_REPEAT: begin
            codes.push_back(RSP_ACK);
            kb_rate_idx  = hb[4:0];
            kb_delay_idx = hb[6:5];
            kb_phase     = PH_IDLE;
          end
          PH_SCANSET: begin
            codes.push_back(RSP_ACK);
            if (hb == SCAN_SET_QUERY) begin
              codes.push_back(RSP_SET2);
            end
            kb_phase = PH_IDLE;
          end
          PH_KEYLIST: begin
            codes.push_back(RSP_ACK);
          end
          default: begin
            codes.push_back(RSP_ERROR);
            kb_phase = PH_IDLE;
          end
        endcase
      end
    endcase
    // Status fields reflect the state after this byte on every beat.
    foreach (codes[k]) begin
      beat.code      = codes[k];
      beat.last_rsp  = (k == codes.size() - 1);
      beat.led_valid = led_v;
      beat.led_byte  = led_b;
      beat.delay_tk  = DELAY_TICK_TAB[kb_delay_idx];
      beat.rate_tk   = 14'h0000 - RATE_MAG_TAB[kb_rate_idx];
      beat.unlock    = (kb_phase == PH_IDLE);
      expected_beats.push_back(beat);
    end
  endtask

  // Check result beats and predict the beats of each accepted host byte.
  always @(posedge clk) begin : scoreboard
    rsp_beat_t want;
    int        first;
    if (!rst_n) begin
      kb_phase     = PH_IDLE;
      kb_rate_idx  = RATE_IDX_RESET;
      kb_delay_idx = DELAY_IDX_DEFLT;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected beat: code %0d last %0b", out_response_code,
                     out_last_response);
          end
        end else begin
          want = expected_beats.pop_front();
          if (out_response_code !== want.code || out_last_response !== want.last_rsp ||
              out_led_valid !== want.led_valid || out_led_byte !== want.led_byte ||
              out_repeat_delay_ticks !== want.delay_tk ||
              out_repeat_rate_ticks !== want.rate_tk || out_send_unlock !== want.unlock) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat mismatch: expected code %0d last %0b led %0b/%02h",
                       want.code, want.last_rsp, want.led_valid, want.led_byte,
                       " delay %0d rate %0d unlock %0b", want.delay_tk, want.rate_tk,
                       want.unlock);
              $display("               actual   code %0d last %0b led %0b/%02h",
                       out_response_code, out_last_response, out_led_valid,
                       out_led_byte, " delay %0d rate %0d unlock %0b",
                       out_repeat_delay_ticks, out_repeat_rate_ticks, out_send_unlock);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        first = expected_beats.size();
        respond_to_host_byte(in_host_byte);
        // Typed rows replace the predicted first code and status fields.
        if (host_rows[rows_taken].typed) begin
          for (int k = first; k < expected_beats.size(); k++) begin
            if (k == first) begin
              expected_beats[k].code = host_rows[rows_taken].code;
            end
            expected_beats[k].delay_tk = host_rows[rows_taken].delay_tk;
            expected_beats[k].rate_tk  = host_rows[rows_taken].rate_tk;
            expected_beats[k].unlock   = host_rows[rows_taken].unlock;
          end
        end
        rows_taken++;
      end
    end
  end

  // Receiver stalls follow a randomly chosen mode that is redrawn when its span runs out.
  always @(posedge clk) begin : receiver
    int unsigned stall_mode;
    int unsigned mode_left;
    logic [2:0]  stall_tick;
    if (!rst_n) begin
      stall_mode = 0;
      mode_left  = 0;
      stall_tick = '0;
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 200);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (stall_tick < 3'd3);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // A hung block shows up as a long stretch with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no beat for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build the byte sequence, reset the block and send every byte.
  initial begin : sender
    int          n_directed;
    int unsigned pick;
    int unsigned burst_left;
    int unsigned gap;

    // Directed part: error after reset, reset command, typematic extremes,
    // scan set query, key list with resend, every remaining command.
    add_typed_row(8'h00, RSP_ERROR, 14'd7500, -14'sd1000, 1'b1);
    add_typed_row(CMD_RESET, RSP_ACK, 14'd7500, -14'sd1376, 1'b1);
    add_row(CMD_SET_LEDS);
    add_row(8'hEC);
    add_row(CMD_TYPEMATIC);
    add_typed_row(8'h00, RSP_ACK, 14'd3750, -14'sd500, 1'b1);
    add_row(CMD_TYPEMATIC);
    add_typed_row(8'h7F, RSP_ACK, 14'd15000, -14'sd7500, 1'b1);
    add_row(CMD_TYPEMATIC);
    add_row(8'hE5);
    add_row(CMD_SCAN_SET);
    add_row(SCAN_SET_QUERY);
    add_row(CMD_SCAN_SET);
    add_row(8'h02);
    add_row(CMD_READ_ID);
    add_row(CMD_ECHO);
    add_row(CMD_KEY_TM);
    add_row(8'h1C);
    add_row(CMD_RESEND);
    add_row(8'hF1);
    add_row(CMD_KEY_MB);
    add_row(CMD_KEY_MK);
    add_row(CMD_ENABLE);
    add_row(CMD_DEFAULTS);
    add_row(CMD_DISABLE);
    add_row(CMD_ALL_TM);
    add_row(CMD_ALL_MB);
    add_row(CMD_ALL_MK);
    add_row(CMD_ALL_TMB);
    add_typed_row(8'hEF, RSP_ERROR, 14'd7500, -14'sd1376, 1'b1);
    n_directed = host_rows.size();

    // Random part: mostly well-formed command sequences, some broken ones.
    while (host_rows.size() < n_directed + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        add_row(CMD_SET_LEDS);
        add_row(argument_byte());
      end else if (pick < 38) begin
        add_row(CMD_TYPEMATIC);
        add_row(argument_byte());
      end else if (pick < 52) begin
        add_row(CMD_SCAN_SET);
        add_row(($urandom_range(0, 2) == 0) ? SCAN_SET_QUERY : argument_byte());
      end else if (pick < 64) begin
        add_row(8'($urandom_range(CMD_KEY_TM, CMD_KEY_MK)));
        repeat ($urandom_range(1, 6)) begin
          add_row(($urandom_range(0, 9) == 0) ? CMD_RESEND : argument_byte());
        end
      end else if (pick < 80) begin
        add_row(($urandom_range(0, 6) == 0) ? CMD_ECHO
                                            : 8'($urandom_range(CMD_READ_ID, CMD_RESET)));
      end else if (pick < 90) begin
        // A command whose argument is mostly cut short by another command byte.
        case ($urandom_range(0, 2))
          0: add_row(CMD_SET_LEDS);
          1: add_row(CMD_TYPEMATIC);
          default: add_row(CMD_SCAN_SET);
        endcase
        add_row(8'($urandom_range(CMD_SET_LEDS, CMD_RESET)));
      end else begin
        add_row(8'($urandom_range(0, 255)));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = 0;
    for (int i = 0; i < host_rows.size(); i++) begin
      // Drain everything at the start of the random part and halfway through.
      if (i == n_directed || i == n_directed + RANDOM_BYTES / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (burst_left != 0) begin
        burst_left--;
      end
      in_valid     <= 1'b1;
      in_host_byte <= host_rows[i].hb;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    // Wait for the last beats, then watch for strays.
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0d expected beats never arrived", expected_beats.size());
    end
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== ps2_keyboard_command_responder_core.f =====
+incdir+src
src/kbdcr_pkg.sv
src/ps2_keyboard_command_responder_core.sv
tb/sv/testbench.sv
